// ===== rtl/core/hlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hlcd_pkg
// Shared types and constants of the header/length/checksum deframer.
// ----------------------------------------------------------------------------
package hlcd_pkg;

   // header bytes
   localparam logic [7:0] HDR_FIRST  = 8'hFF;
   localparam logic [7:0] HDR_SECOND = 8'h55;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_CKSUM = 2'd1;
   localparam logic [1:0] ST_LEN   = 2'd2;

   // width of the length limit register
   localparam int unsigned LIMIT_W = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd21;

   // event from the parser to the emitter
   typedef struct packed {
      logic       valid;     // an event happens this cycle
      logic       is_frame;  // good frame stored, start readout
      logic [1:0] status;    // status of an error result
   } evt_type;

   // status from the emitter back to the parser
   typedef struct packed {
      logic busy;      // readout of a frame in progress
      logic out_free;  // output register can take a word this cycle
   } emit_status_type;

endpackage

// ===== rtl/core/header_length_checksum_deframer.sv =====
// An error word is valid in the cycle after the edge that takes the byte causing it;
//   the first word of a good frame passes the READ and LOAD states after the edge that takes its checksum.
// Throughput: one byte per cycle while no frame is read out and, past the header, the output
//   register can take a word; a good frame is read out of the frame buffer word by word (RAM
//   read, then output load), so input is stalled after its checksum byte until the readout,
//   which result-side stalls prolong, is done. Reset: synchronous, active high; clears the
//   parser and readout state and sets the length limit to 21. The frame buffer is not cleared.
// ----------------------------------------------------------------------------
// header_length_checksum_deframer
// Finds 0xFF 0x55 framed packets, checks length and additive checksum, and
// emits good frames word by word or a single error word.
// ----------------------------------------------------------------------------
module header_length_checksum_deframer #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_frame_byte,
   output logic                          rsp_frame_last,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_wr_en,
   input  logic [hlcd_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import hlcd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FRAME);
   localparam int unsigned CW = $clog2(MAX_FRAME + 1);

   evt_type          evt;
   emit_status_type  emit_status;
   logic [CW-1:0]    evt_last_idx;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [7:0]       mem_rd_data;

   // header hunt, checks and buffer writes
   hlcd_parser #(.MAX_FRAME(MAX_FRAME)) u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .emit_status  (emit_status),
      .evt          (evt),
      .evt_last_idx (evt_last_idx),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   // frame buffer
   hlcd_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // readout and result register
   hlcd_emitter #(.MAX_FRAME(MAX_FRAME)) u_emitter (
      .clock          (clock),
      .reset          (reset),
      .evt            (evt),
      .evt_last_idx   (evt_last_idx),
      .emit_status    (emit_status),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== rtl/core/hlcd_ram.sv =====
// ----------------------------------------------------------------------------
// hlcd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hlcd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hlcd_parser.sv =====
// ----------------------------------------------------------------------------
// hlcd_parser
// Header hunt, length check, running checksum and frame buffer writes.
// ----------------------------------------------------------------------------
module hlcd_parser #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   input  logic                                 csr_wr_en,
   input  logic [hlcd_pkg::LIMIT_W-1:0]         csr_wr_data,
   input  hlcd_pkg::emit_status_type            emit_status,
   output hlcd_pkg::evt_type                    evt,
   output logic [$clog2(MAX_FRAME+1)-1:0]       evt_last_idx,
   output logic                                 mem_wr_en,
   output logic [$clog2(MAX_FRAME)-1:0]         mem_wr_addr,
   output logic [7:0]                           mem_wr_data
);
   import hlcd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FRAME);
   localparam int unsigned CW = $clog2(MAX_FRAME + 1);
   localparam logic [9:0]  MaxLim = 10'(MAX_FRAME);

   typedef enum logic [1:0] {
      HUNT_FF,
      HUNT_55,
      LENGTH,
      BODY
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         len_ff, len_in;
   logic [7:0]            sum_ff, sum_in;
   logic [LIMIT_W-1:0]    limit_reg_ff;

   logic                  accept;
   logic [9:0]            limit;
   logic                  len_bad;
   logic                  at_cksum;

   // hold input while a frame is read out, or while a result could not be placed
   always_comb begin
      req_stall = emit_status.busy ||
                  (((phase_ff == LENGTH) || (phase_ff == BODY)) && !emit_status.out_free);
   end

   assign accept   = req_valid && !req_stall;
   assign limit    = ({3'd0, limit_reg_ff} > MaxLim) ? MaxLim : {3'd0, limit_reg_ff};
   assign len_bad  = (req_rx_byte < 8'd2) || (({2'd0, req_rx_byte} + 10'd2) > limit);
   assign at_cksum = (count_ff >= CW'(len_ff + 1'b1));

   // next state, buffer writes and events
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      evt          = '0;
      evt_last_idx = CW'(len_ff + 1'b1);
      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[AW-1:0];
      mem_wr_data  = req_rx_byte;
      if (accept) begin
         case (phase_ff)
            HUNT_FF: begin
               if (req_rx_byte == HDR_FIRST) begin
                  phase_in = HUNT_55;
               end
            end
            HUNT_55: begin
               if (req_rx_byte == HDR_SECOND) begin
                  phase_in = LENGTH;
               end else if (req_rx_byte != HDR_FIRST) begin
                  phase_in = HUNT_FF;
               end
            end
            LENGTH: begin
               if (len_bad) begin
                  evt.valid  = 1'b1;
                  evt.status = ST_LEN;
                  phase_in   = HUNT_FF;
                  count_in   = '0;
                  len_in     = '0;
                  sum_in     = '0;
               end else begin
                  // header bytes are supplied on readout; store the length byte
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = AW'(2);
                  len_in      = CW'(req_rx_byte);
                  count_in    = CW'(3);
                  sum_in      = req_rx_byte;
                  phase_in    = BODY;
               end
            end
            BODY: begin
               if (at_cksum) begin
                  evt.valid = 1'b1;
                  if (req_rx_byte != sum_ff) begin
                     evt.status = ST_CKSUM;
                  end else begin
                     evt.is_frame = 1'b1;
                     evt.status   = ST_OK;
                     mem_wr_en    = 1'b1;
                  end
                  phase_in = HUNT_FF;
                  count_in = '0;
                  len_in   = '0;
                  sum_in   = '0;
               end else begin
                  mem_wr_en = 1'b1;
                  count_in  = CW'(count_ff + 1'b1);
                  sum_in    = sum_ff + req_rx_byte;
               end
            end
            default: begin
               phase_in = HUNT_FF;
            end
         endcase
      end
   end

   // state and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= HUNT_FF;
         count_ff     <= '0;
         len_ff       <= '0;
         sum_ff       <= '0;
         limit_reg_ff <= LIMIT_RESET;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         if (csr_wr_en) begin
            limit_reg_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ===== rtl/core/hlcd_emitter.sv =====
// ----------------------------------------------------------------------------
// hlcd_emitter
// Reads a stored frame back from the buffer and drives the result register.
// ----------------------------------------------------------------------------
module hlcd_emitter #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hlcd_pkg::evt_type              evt,
   input  logic [$clog2(MAX_FRAME+1)-1:0] evt_last_idx,
   output hlcd_pkg::emit_status_type      emit_status,
   output logic                           mem_rd_en,
   output logic [$clog2(MAX_FRAME)-1:0]   mem_rd_addr,
   input  logic [7:0]                     mem_rd_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_frame_byte,
   output logic                           rsp_frame_last,
   output logic [1:0]                     rsp_status
);
   import hlcd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FRAME);
   localparam int unsigned CW = $clog2(MAX_FRAME + 1);

   typedef enum logic [1:0] {
      IDLE,
      READ,
      LOAD
   } state_type;

   state_type      state_ff;
   logic [CW-1:0]  idx_ff;
   logic [CW-1:0]  last_idx_ff;
   logic           valid_ff;
   logic [7:0]     byte_ff;
   logic           last_ff;
   logic [1:0]     status_ff;

   logic           out_free;
   logic           load_word;
   logic [7:0]     rd_byte;

   assign out_free          = !valid_ff || !rsp_stall;
   assign emit_status.busy     = (state_ff != IDLE);
   assign emit_status.out_free = out_free;

   // a word enters the output register on an error event or a frame byte load
   assign load_word = ((state_ff == IDLE) && evt.valid && !evt.is_frame) ||
                      ((state_ff == LOAD) && out_free);

   assign mem_rd_en   = (state_ff == READ);
   assign mem_rd_addr = idx_ff[AW-1:0];

   // header bytes are constants, the rest comes from the buffer
   always_comb begin
      if (idx_ff == CW'(0)) begin
         rd_byte = HDR_FIRST;
      end else if (idx_ff == CW'(1)) begin
         rd_byte = HDR_SECOND;
      end else begin
         rd_byte = mem_rd_data;
      end
   end

   // readout sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load_word) begin
            valid_ff <= 1'b1;
         end else if (valid_ff && !rsp_stall) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (evt.valid) begin
                  if (evt.is_frame) begin
                     idx_ff      <= '0;
                     last_idx_ff <= evt_last_idx;
                     state_ff    <= READ;
                  end else begin
                     byte_ff   <= '0;
                     last_ff   <= 1'b1;
                     status_ff <= evt.status;
                  end
               end
            end
            READ: begin
               state_ff <= LOAD;
            end
            LOAD: begin
               if (out_free) begin
                  byte_ff   <= rd_byte;
                  last_ff   <= (idx_ff == last_idx_ff);
                  status_ff <= ST_OK;
                  if (idx_ff == last_idx_ff) begin
                     state_ff <= IDLE;
                  end else begin
                     idx_ff   <= CW'(idx_ff + 1'b1);
                     state_ff <= READ;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_last = last_ff;
   assign rsp_status     = status_ff;

endmodule
